[rtl/assert_macros.svh]
// Assertion macros shared by the cantor set membership RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define CSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that must also hold during reset
`define CSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/csm_pkg.sv]
// Shared types and constants for the cantor set membership block.
// No dependencies; used by csm_ctrl, csm_datapath and the top level.
package csm_pkg;

    // field and register widths
    localparam int INDEX_BITS = 16;
    localparam int DEPTH_W    = 5;
    localparam int MULT_W     = 8;
    localparam int MOD_W      = 16;
    localparam int COEF_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int PROD_W     = INDEX_BITS + MULT_W;
    localparam int BOUND_W    = COEF_W + MOD_W;
    localparam int FRAC_BITS  = 8;
    localparam int REM_W      = MOD_W + 1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_GROUPS = PROD_W / DIV_BITS;
    localparam int GRP_W      = $clog2(DIV_GROUPS);

    // register reset values
    localparam logic [DEPTH_W-1:0] LEVEL_COUNT_RST = DEPTH_W'(5);
    localparam logic [MULT_W-1:0]  MULTIPLIER_RST  = MULT_W'(3);
    localparam logic [MOD_W-1:0]   MODULUS_RST     = MOD_W'(80);
    localparam logic [COEF_W-1:0]  GAP_COEF_RST    = COEF_W'(512);

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEVEL_COUNT = 2'd0,
        CFG_MULTIPLIER  = 2'd1,
        CFG_MODULUS     = 2'd2,
        CFG_GAP_COEF    = 2'd3
    } t_cfg_reg;

    // item function codes
    localparam logic FUNC_NEXT  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic bound;
        logic mul;
        logic div;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic depth_zero;
        logic depth_one;
        logic div_last;
    } t_status;

endpackage

[rtl/csm_ctrl.sv]
// Sequencer for the cantor set membership block: item intake, level loop, result hand-off.
// Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  csm_pkg::t_status   i_status,
    output csm_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    // result register may be refilled once empty or being drained this cycle
    assign slot_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BOUND;
                end
            end
            ST_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = i_status.depth_zero ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = i_status.depth_one ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // a taken beat starts work, so intake closes on the next cycle
    `CSM_ASSERT(a_intake_closes, (i_in_valid && o_in_ready) |=> !o_in_ready,
        "intake still open after an input beat")
    // a waiting result is never overwritten
    `CSM_ASSERT(a_no_overwrite, o_cmd.out_load |-> (!r_out_valid || i_out_ready),
        "result register refilled while a beat was pending")
    // level loop only runs for a non-zero depth
    `CSM_ASSERT(a_mul_needs_depth, o_cmd.mul |-> !i_status.depth_zero,
        "level started with no depth left")

endmodule

[rtl/csm_datapath.sv]
// Datapath: configuration registers, step counter, product, band compare and
// 4-bit-per-cycle restoring remainder unit. Depends on csm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csm_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [csm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_func,
    input  logic [csm_pkg::DEPTH_W-1:0]        i_query_depth,
    input  logic [csm_pkg::INDEX_BITS-1:0]     i_query_index,
    input  csm_pkg::t_cmd                      i_cmd,
    output csm_pkg::t_status                   o_status,
    output logic                               o_in_set,
    output logic [csm_pkg::INDEX_BITS-1:0]     o_tested_index
);

    localparam logic [csm_pkg::GRP_W-1:0] GRP_LAST = csm_pkg::GRP_W'(csm_pkg::DIV_GROUPS - 1);

    // configuration and counter state
    logic [csm_pkg::DEPTH_W-1:0]    r_level_count;
    logic [csm_pkg::MULT_W-1:0]     r_multiplier;
    logic [csm_pkg::MOD_W-1:0]      r_modulus;
    logic [csm_pkg::COEF_W-1:0]     r_gap_coef;
    logic [csm_pkg::INDEX_BITS-1:0] r_step_cnt;

    // per-item working registers
    logic [csm_pkg::INDEX_BITS-1:0] r_index;
    logic [csm_pkg::DEPTH_W-1:0]    r_depth;
    logic [csm_pkg::INDEX_BITS-1:0] r_y;
    logic [csm_pkg::PROD_W-1:0]     r_p;
    logic [csm_pkg::PROD_W-1:0]     r_shift;
    logic [csm_pkg::REM_W-1:0]      r_rem;
    logic [csm_pkg::BOUND_W-1:0]    r_bound;
    logic [csm_pkg::GRP_W-1:0]      r_grp;
    logic                           r_member;

    logic [csm_pkg::PROD_W-1:0]     n_p;
    logic [csm_pkg::BOUND_W-1:0]    n_bound;
    logic [csm_pkg::REM_W-1:0]      n_rem;
    logic                           band_hit;
    logic [csm_pkg::REM_W-1:0]      mod_ext;

    assign mod_ext = {1'b0, r_modulus};

    // multipliers: running value by scale factor, and the band bound
    assign n_p     = {{csm_pkg::INDEX_BITS{1'b0}}, r_multiplier}
                   * {{csm_pkg::MULT_W{1'b0}}, r_y};
    assign n_bound = {{csm_pkg::MOD_W{1'b0}}, r_gap_coef}
                   * {{csm_pkg::COEF_W{1'b0}}, r_modulus};

    // excluded band: modulus <= p and 256*p < gap_coef*modulus
    assign band_hit = (r_p >= {{csm_pkg::MULT_W{1'b0}}, r_modulus})
                   && ({r_p, {csm_pkg::FRAC_BITS{1'b0}}} < r_bound);

    // restoring remainder, DIV_BITS quotient bits per cycle, MSB first
    always_comb begin
        n_rem = r_rem;
        for (int k = 0; k < csm_pkg::DIV_BITS; k++) begin
            n_rem = {n_rem[csm_pkg::REM_W-2:0], r_shift[csm_pkg::PROD_W-1-k]};
            if (n_rem >= mod_ext) begin
                n_rem = n_rem - mod_ext;
            end
        end
    end

    // configuration registers and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= csm_pkg::LEVEL_COUNT_RST;
            r_multiplier  <= csm_pkg::MULTIPLIER_RST;
            r_modulus     <= csm_pkg::MODULUS_RST;
            r_gap_coef    <= csm_pkg::GAP_COEF_RST;
            r_step_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (csm_pkg::t_cfg_reg'(i_cfg_addr))
                    csm_pkg::CFG_LEVEL_COUNT: r_level_count <= i_cfg_wdata[csm_pkg::DEPTH_W-1:0];
                    csm_pkg::CFG_MULTIPLIER:  r_multiplier  <= i_cfg_wdata[csm_pkg::MULT_W-1:0];
                    csm_pkg::CFG_MODULUS:     r_modulus     <= i_cfg_wdata[csm_pkg::MOD_W-1:0];
                    csm_pkg::CFG_GAP_COEF:    r_gap_coef    <= i_cfg_wdata[csm_pkg::COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load && (i_func == csm_pkg::FUNC_NEXT)) begin
                r_step_cnt <= r_step_cnt + 1'b1;
            end
        end
    end

    // group counter of the remainder unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else if (i_cmd.mul) begin
            r_grp <= '0;
        end else if (i_cmd.div) begin
            r_grp <= (r_grp == GRP_LAST) ? '0 : r_grp + 1'b1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_member <= 1'b1;
            if (i_func == csm_pkg::FUNC_NEXT) begin
                r_depth <= r_level_count;
                r_index <= r_step_cnt;
                r_y     <= r_step_cnt;
            end else begin
                r_depth <= i_query_depth;
                r_index <= i_query_index;
                r_y     <= i_query_index;
            end
        end
        if (i_cmd.bound) begin
            r_bound <= n_bound;
        end
        if (i_cmd.mul) begin
            r_p     <= n_p;
            r_shift <= n_p;
            r_rem   <= '0;
        end
        if (i_cmd.div) begin
            r_rem   <= n_rem;
            r_shift <= {r_shift[csm_pkg::PROD_W-csm_pkg::DIV_BITS-1:0],
                        {csm_pkg::DIV_BITS{1'b0}}};
            if (r_grp == GRP_LAST) begin
                // level finished: band test and new running value
                if (band_hit) begin
                    r_member <= 1'b0;
                end
                r_y     <= (r_modulus == '0) ? '0 : n_rem[csm_pkg::INDEX_BITS-1:0];
                r_depth <= r_depth - 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            o_in_set       <= r_member;
            o_tested_index <= r_index;
        end
    end

    assign o_status.depth_zero = (r_depth == '0);
    assign o_status.depth_one  = (r_depth == csm_pkg::DEPTH_W'(1));
    assign o_status.div_last   = (r_grp == GRP_LAST);

    // group counter never leaves its range
    `CSM_ASSERT_ALWAYS(a_grp_range, !i_rst_n || (r_grp <= GRP_LAST),
        "remainder group counter out of range")
    // partial remainder stays below a non-zero modulus
    `CSM_ASSERT(a_rem_bound, ($past(i_cmd.div) && (r_modulus != '0)) |-> (r_rem < mod_ext),
        "partial remainder not reduced")

endmodule

[rtl/cantor_set_membership_core.sv]
// Generalised Cantor set membership test.
// Input channel: i_in_valid / o_in_ready, beat = {i_func, i_query_depth, i_query_index}.
// i_func next (0) tests the internal step counter over level_count levels and then
// advances the counter (wraps at 16 bits); query (1) tests i_query_index over
// i_query_depth levels. Output channel: o_out_valid / i_out_ready, beat =
// {o_in_set, o_tested_index}; exactly one result beat per input beat, in order.
// Configuration: i_cfg_we, i_cfg_addr, i_cfg_wdata; write only while idle.
// Each level forms the 8x16 product, then the remainder unit retires 4 bits of the
// 24-bit product per cycle.
// One item is in work at a time; the next one is taken while a finished result
// waits in the output register.
// Stall: a held result blocks only the hand-off of the following result; that
// item waits finished until the output register drains.
// Reset (synchronous, active low): registers take level_count 5, multiplier 3,
// modulus 80, gap_coef 2.0 (Q8.8), the step counter clears and no beat is pending.
// Depends on csm_pkg, csm_ctrl and csm_datapath.
module cantor_set_membership_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [csm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_func,
    input  logic [csm_pkg::DEPTH_W-1:0]        i_query_depth,
    input  logic [csm_pkg::INDEX_BITS-1:0]     i_query_index,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_in_set,
    output logic [csm_pkg::INDEX_BITS-1:0]     o_tested_index
);

    csm_pkg::t_cmd    cmd;
    csm_pkg::t_status status;

    // sequencer
    csm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic and storage
    csm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_func),
        .i_query_depth  (i_query_depth),
        .i_query_index  (i_query_index),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_in_set       (o_in_set),
        .o_tested_index (o_tested_index)
    );

endmodule
